// ===== design/lookahead_waypoint_search_assert.svh =====
// assertion macros for the lookahead waypoint search
// expects clk and rst_n in the scope where the macros are used
`ifndef LOOKAHEAD_WAYPOINT_SEARCH_ASSERT_SVH
`define LOOKAHEAD_WAYPOINT_SEARCH_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LWS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lookahead waypoint search: same-cycle check failed");

// next-cycle implication
`define LWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lookahead waypoint search: next-cycle check failed");

`endif

// ===== design/lws_pkg.sv =====
// shared types and constants of the lookahead waypoint search
// no dependencies; used by the stream interface users, controller, datapath and top
`default_nettype none

package lws_pkg;

    // field widths
    localparam int COORD_W   = 24;
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 11;
    localparam int LA_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // corner test geometry
    localparam int CORNER_OFFSET = 60;
    localparam int TAN_W         = 30;
    // tan(10 deg) in unsigned q0.32
    localparam logic [TAN_W-1:0] TAN10_Q32 = 30'd757318616;

    // datapath widths
    localparam int VEC_W  = COORD_W + 1;
    localparam int OPND_W = 31;
    localparam int PROD_W = 2 * OPND_W;
    localparam int DIST_W = 2 * COORD_W + 2;
    localparam int MAG_W  = 2 * VEC_W + 2;
    localparam int HALF_W = MAG_W / 2;
    localparam int CMP_W  = MAG_W + 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD   = 1'd1;

    localparam logic [LA_W-1:0] LOOKAHEAD_RESET = 16'd400;

    // request function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_CROSS,
        MUL_DOT,
        MUL_TAN
    } mul_sel_t;

    typedef struct packed {
        logic                       func;
        logic [IDX_W-1:0]           wp_index;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
    } req_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] target_index;
        logic [IDX_W-1:0] nearest_index;
        logic             corner;
        logic             path_empty;
    } res_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic     wr_en;
        logic     start;
        logic     rd_en;
        logic     sample;
        logic     ref_load;
        logic     cmp_near;
        logic     cmp_tgt;
        logic     tgt_init;
        logic     a_load;
        logic     b_load;
        mul_sel_t mul_sel;
        logic     cr_load;
        logic     dt_load;
        logic     corner_eval;
        logic     out_load;
        logic     out_empty;
    } lws_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pipe_busy;
    } lws_stat_t;

endpackage

`default_nettype wire

// ===== design/lws_stream_if.sv =====
// valid/ready stream channel carrying one request or result per handshake
// payload type is given by the instantiating context
`default_nettype none

interface lws_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/lws_datapath.sv =====
// datapath: waypoint memory, distance pipeline, corner arithmetic, result register
// depends on lws_pkg
`default_nettype none

module lws_datapath #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lws_pkg::lws_cmd_t             cmd,
    input  wire lws_pkg::req_item_t            req,
    input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    input  wire logic [$clog2(MAX_POINTS)-1:0] tgt_default,
    input  wire logic [lws_pkg::LA_W-1:0]      lookahead,
    output lws_pkg::lws_stat_t                 stat,
    output logic [$clog2(MAX_POINTS)-1:0]      near_index,
    output lws_pkg::res_item_t                 res
);
    import lws_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    point_t                    mem [MAX_POINTS];
    point_t                    rd_reg;
    point_t                    ref_reg;
    logic                      v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]             idx1_reg, idx2_reg, idx3_reg;
    logic signed [VEC_W-1:0]   dx_reg, dy_reg;
    logic signed [VEC_W-1:0]   ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg;
    logic [DIST_W-1:0]         best_reg;
    logic [IW-1:0]             near_reg, tgt_reg;
    logic                      found_reg, corner_reg;
    logic [2*LA_W-1:0]         l2_reg;
    logic [MAG_W-1:0]          cr_reg, dt_reg;
    res_item_t                 out_reg;

    logic signed [OPND_W-1:0]  m0a, m0b, m1a, m1b;
    logic [DIST_W-1:0]         dist_sq;
    logic                      seg_zero;
    logic signed [VEC_W-1:0]   seg_x;
    logic signed [PROD_W-1:0]  cross_w, dot_w, cross_abs, dot_abs;
    logic [CMP_W-1:0]          lhs, rhs;

    function automatic logic signed [OPND_W-1:0] vext(input logic signed [VEC_W-1:0] v);
        vext = {{(OPND_W-VEC_W){v[VEC_W-1]}}, v};
    endfunction

    // waypoint memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && (32'(req.wp_index) < MAX_POINTS))
        begin
            mem[IW'(req.wp_index)] <= '{x: req.pos_x, y: req.pos_y};
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // sample valid bits of the distance pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en && cmd.sample;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // multiplier operand selection
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SQ:
            begin
                m0a = vext(dx_reg);
                m0b = vext(dx_reg);
                m1a = vext(dy_reg);
                m1b = vext(dy_reg);
            end
            MUL_CROSS:
            begin
                m0a = vext(ax_reg);
                m0b = vext(by_reg);
                m1a = vext(ay_reg);
                m1b = vext(bx_reg);
            end
            MUL_DOT:
            begin
                m0a = vext(ax_reg);
                m0b = vext(bx_reg);
                m1a = vext(ay_reg);
                m1b = vext(by_reg);
            end
            MUL_TAN:
            begin
                m0a = {{(OPND_W-HALF_W){1'b0}}, dt_reg[HALF_W-1:0]};
                m0b = {{(OPND_W-TAN_W){1'b0}}, TAN10_Q32};
                m1a = {{(OPND_W-HALF_W){1'b0}}, dt_reg[MAG_W-1:HALF_W]};
                m1b = {{(OPND_W-TAN_W){1'b0}}, TAN10_Q32};
            end
            default:
            begin
                m0a = '0;
                m0b = '0;
                m1a = '0;
                m1b = '0;
            end
        endcase
    end

    // squared distance, segment fix-up, cross/dot magnitudes, corner compare
    always_comb
    begin
        dist_sq   = p0_reg[DIST_W-1:0] + p1_reg[DIST_W-1:0];
        seg_zero  = (dx_reg == '0) && (dy_reg == '0);
        seg_x     = seg_zero ? VEC_W'(1) : dx_reg;
        cross_w   = p0_reg - p1_reg;
        dot_w     = p0_reg + p1_reg;
        cross_abs = cross_w[PROD_W-1] ? -cross_w : cross_w;
        dot_abs   = dot_w[PROD_W-1] ? -dot_w : dot_w;
        lhs       = {cr_reg, 32'd0};
        rhs       = CMP_W'(p0_reg[HALF_W+TAN_W-1:0])
                  + CMP_W'({p1_reg[HALF_W+TAN_W-1:0], {HALF_W{1'b0}}});
    end

    // pipeline stages and search registers
    always_ff @(posedge clk)
    begin
        idx1_reg <= rd_addr;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        dx_reg   <= {rd_reg.x[COORD_W-1], rd_reg.x} - {ref_reg.x[COORD_W-1], ref_reg.x};
        dy_reg   <= {rd_reg.y[COORD_W-1], rd_reg.y} - {ref_reg.y[COORD_W-1], ref_reg.y};
        p0_reg   <= m0a * m0b;
        p1_reg   <= m1a * m1b;
        l2_reg   <= lookahead * lookahead;

        // reference point: query position, then segment start points
        if (cmd.start)
        begin
            ref_reg <= '{x: req.pos_x, y: req.pos_y};
        end
        else if (cmd.ref_load)
        begin
            ref_reg <= rd_reg;
        end

        // nearest search, first index wins on ties
        if (cmd.start)
        begin
            best_reg <= '1;
        end
        else if (v3_reg && cmd.cmp_near && (dist_sq < best_reg))
        begin
            best_reg <= dist_sq;
            near_reg <= idx3_reg;
        end

        // first waypoint beyond the lookahead
        if (cmd.tgt_init)
        begin
            tgt_reg   <= tgt_default;
            found_reg <= 1'b0;
        end
        else if (v3_reg && cmd.cmp_tgt && !found_reg
                 && (dist_sq > {{(DIST_W-2*LA_W){1'b0}}, l2_reg}))
        begin
            tgt_reg   <= idx3_reg;
            found_reg <= 1'b1;
        end

        // segment directions
        if (cmd.a_load)
        begin
            ax_reg <= seg_x;
            ay_reg <= dy_reg;
        end
        if (cmd.b_load)
        begin
            bx_reg <= seg_x;
            by_reg <= dy_reg;
        end
        if (cmd.cr_load)
        begin
            cr_reg <= cross_abs[MAG_W-1:0];
        end
        if (cmd.dt_load)
        begin
            dt_reg <= dot_abs[MAG_W-1:0];
        end

        if (cmd.start)
        begin
            corner_reg <= 1'b0;
        end
        else if (cmd.corner_eval)
        begin
            corner_reg <= lhs > rhs;
        end

        // result register
        if (cmd.out_load)
        begin
            if (cmd.out_empty)
            begin
                out_reg <= '{target_index: '0, nearest_index: '0, corner: 1'b0,
                             path_empty: 1'b1};
            end
            else
            begin
                out_reg <= '{target_index: IDX_W'(tgt_reg), nearest_index: IDX_W'(near_reg),
                             corner: corner_reg, path_empty: 1'b0};
            end
        end
    end

    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign near_index     = near_reg;
    assign res            = out_reg;

endmodule

`default_nettype wire

// ===== design/lws_ctrl.sv =====
// controller: sequences the two path scans and the corner test, owns the result valid
// depends on lws_pkg
`default_nettype none

module lws_ctrl #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_func,
    output logic                               req_ready,
    input  wire logic [lws_pkg::LEN_W-1:0]     path_length,
    input  wire logic [$clog2(MAX_POINTS)-1:0] near_index,
    input  wire lws_pkg::lws_stat_t            stat,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output lws_pkg::lws_cmd_t                  cmd,
    output logic [$clog2(MAX_POINTS)-1:0]      rd_addr,
    output logic [$clog2(MAX_POINTS)-1:0]      tgt_default
);
    import lws_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [16:0] {
        S_IDLE   = 17'b0_0000_0000_0000_0001,
        S_NSCAN  = 17'b0_0000_0000_0000_0010,
        S_NDRAIN = 17'b0_0000_0000_0000_0100,
        S_TSCAN  = 17'b0_0000_0000_0000_1000,
        S_TDRAIN = 17'b0_0000_0000_0001_0000,
        S_CRD0   = 17'b0_0000_0000_0010_0000,
        S_CRD1   = 17'b0_0000_0000_0100_0000,
        S_CRD2   = 17'b0_0000_0000_1000_0000,
        S_CRD3   = 17'b0_0000_0001_0000_0000,
        S_CWAIT  = 17'b0_0000_0010_0000_0000,
        S_CBLD   = 17'b0_0000_0100_0000_0000,
        S_CMULX  = 17'b0_0000_1000_0000_0000,
        S_CMULD  = 17'b0_0001_0000_0000_0000,
        S_CDOT   = 17'b0_0010_0000_0000_0000,
        S_CTAN   = 17'b0_0100_0000_0000_0000,
        S_CEVAL  = 17'b0_1000_0000_0000_0000,
        S_FINISH = 17'b1_0000_0000_0000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic          empty_reg, empty_next;
    logic          out_valid_reg, out_valid_next;

    logic          accept;
    logic [CW-1:0] n_clamp;
    logic          last_issue;
    logic [IW-1:0] addr_inc;
    logic [IW-1:0] near_plus1, near_off, near_off1;
    logic          corner_skip;

    // address and length arithmetic
    always_comb
    begin
        accept      = req_valid && req_ready;
        n_clamp     = (32'(path_length) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(path_length);
        last_issue  = (cnt_reg == n_reg - CW'(1));
        addr_inc    = ((32'(addr_reg) + 1) == 32'(n_reg)) ? '0 : addr_reg + IW'(1);
        near_plus1  = IW'(32'(near_index) + 1);
        near_off    = IW'(32'(near_index) + CORNER_OFFSET);
        near_off1   = IW'(32'(near_index) + CORNER_OFFSET + 1);
        tgt_default = ((32'(near_index) + 1) == 32'(n_reg)) ? '0 : near_plus1;
        corner_skip = (32'(near_index) + CORNER_OFFSET + 1) >= 32'(n_reg);
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        addr_next      = addr_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_addr        = addr_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_SQ;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_func == FUNC_LOAD)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        n_next    = n_clamp;
                        cnt_next  = '0;
                        addr_next = '0;
                        if (n_clamp == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            empty_next = 1'b0;
                            state_next = S_NSCAN;
                        end
                    end
                end
            end
            S_NSCAN:
            begin
                cmd.rd_en    = 1'b1;
                cmd.sample   = 1'b1;
                cmd.cmp_near = 1'b1;
                if (last_issue)
                begin
                    state_next = S_NDRAIN;
                end
                else
                begin
                    cnt_next  = cnt_reg + CW'(1);
                    addr_next = addr_inc;
                end
            end
            S_NDRAIN:
            begin
                cmd.cmp_near = 1'b1;
                if (!stat.pipe_busy)
                begin
                    cmd.tgt_init = 1'b1;
                    addr_next    = near_index;
                    cnt_next     = '0;
                    state_next   = S_TSCAN;
                end
            end
            S_TSCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.sample  = 1'b1;
                cmd.cmp_tgt = 1'b1;
                if (last_issue)
                begin
                    state_next = S_TDRAIN;
                end
                else
                begin
                    cnt_next  = cnt_reg + CW'(1);
                    addr_next = addr_inc;
                end
            end
            S_TDRAIN:
            begin
                cmd.cmp_tgt = 1'b1;
                if (!stat.pipe_busy)
                begin
                    state_next = corner_skip ? S_FINISH : S_CRD0;
                end
            end
            S_CRD0:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = near_index;
                state_next = S_CRD1;
            end
            S_CRD1:
            begin
                cmd.rd_en    = 1'b1;
                cmd.ref_load = 1'b1;
                rd_addr      = near_plus1;
                state_next   = S_CRD2;
            end
            S_CRD2:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = near_off;
                state_next = S_CRD3;
            end
            S_CRD3:
            begin
                cmd.rd_en    = 1'b1;
                cmd.ref_load = 1'b1;
                cmd.a_load   = 1'b1;
                rd_addr      = near_off1;
                state_next   = S_CWAIT;
            end
            S_CWAIT:
            begin
                state_next = S_CBLD;
            end
            S_CBLD:
            begin
                cmd.b_load = 1'b1;
                state_next = S_CMULX;
            end
            S_CMULX:
            begin
                cmd.mul_sel = MUL_CROSS;
                state_next  = S_CMULD;
            end
            S_CMULD:
            begin
                cmd.mul_sel = MUL_DOT;
                cmd.cr_load = 1'b1;
                state_next  = S_CDOT;
            end
            S_CDOT:
            begin
                cmd.dt_load = 1'b1;
                state_next  = S_CTAN;
            end
            S_CTAN:
            begin
                cmd.mul_sel = MUL_TAN;
                state_next  = S_CEVAL;
            end
            S_CEVAL:
            begin
                cmd.corner_eval = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_empty  = empty_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            addr_reg      <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            addr_reg      <= addr_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/lookahead_waypoint_search.sv =====
// Lookahead waypoint search. Channels: request (sink) takes load and query requests,
// result (source) returns one item per query. A register write port sets path_length
// and lookahead_mm; write it only while no query is in flight or waiting.
// A load request writes one waypoint as it is accepted; it gives no result.
// A query request runs two passes over the path through the single read port of the
// waypoint memory, one waypoint per cycle each: nearest search, then lookahead search
// starting at the nearest point. A corner test over four more reads and a short
// multiply sequence follows, unless the corner window runs past the path end. At most
// 1024 waypoints are in use, however large path_length is; on an empty path both
// passes and the corner test are skipped.
// Requests are taken one at a time: request.ready is high only while no query runs.
// The result sits in an output register; a stalled receiver holds it there, and the
// block keeps taking requests, finishing the next query only once the register frees.
// Reset clears the control state and sets path_length to 0 and lookahead_mm to 400;
// the waypoint memory is not cleared and holds nothing meaningful until loaded.
// Depends on lws_pkg, lws_stream_if, lws_ctrl, lws_datapath.
`default_nettype none

module lookahead_waypoint_search #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lws_pkg::CFG_W-1:0]     cfg_data,
    lws_stream_if.sink                         request,
    lws_stream_if.source                       result
);
    import lws_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);

    logic [LEN_W-1:0] path_length_reg;
    logic [LA_W-1:0]  lookahead_reg;

    lws_cmd_t         cmd;
    lws_stat_t        stat;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    tgt_default;
    logic [IW-1:0]    near_index;
    logic             req_ready;
    logic             out_valid;
    res_item_t        res;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_length_reg <= '0;
            lookahead_reg   <= LOOKAHEAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATH_LENGTH: path_length_reg <= cfg_data[LEN_W-1:0];
                CFG_LOOKAHEAD:   lookahead_reg   <= cfg_data[LA_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer
    lws_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (request.valid),
        .req_func    (request.data.func),
        .req_ready   (req_ready),
        .path_length (path_length_reg),
        .near_index  (near_index),
        .stat        (stat),
        .out_ready   (result.ready),
        .out_valid   (out_valid),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .tgt_default (tgt_default)
    );

    // memory and arithmetic
    lws_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req         (request.data),
        .rd_addr     (rd_addr),
        .tgt_default (tgt_default),
        .lookahead   (lookahead_reg),
        .stat        (stat),
        .near_index  (near_index),
        .res         (res)
    );

    assign request.ready = req_ready;
    assign result.valid  = out_valid;
    assign result.data   = res;

    // checks
    `include "lookahead_waypoint_search_assert.svh"

    `LWS_ASSERT_IMPLIES(a_empty_fields_zero, result.valid && result.data.path_empty, result.data.target_index == '0 && result.data.nearest_index == '0 && !result.data.corner)
    `LWS_ASSERT_IMPLIES(a_empty_matches_length, result.valid, result.data.path_empty == (path_length_reg == '0))
    `LWS_ASSERT_IMPLIES(a_index_in_path, result.valid && !result.data.path_empty, ({1'b0, result.data.nearest_index} < path_length_reg) && ({1'b0, result.data.target_index} < path_length_reg))
    `LWS_ASSERT_NEXT(a_query_goes_busy, request.valid && request.ready && request.data.func == FUNC_QUERY, !request.ready)

endmodule

`default_nettype wire

// ===== verif/tb_lookahead_waypoint_search.sv =====
// self-checking testbench for the lookahead waypoint search
// depends on lws_pkg, lws_stream_if and the lookahead_waypoint_search top level
module tb_lookahead_waypoint_search;
    timeunit 1ns;
    timeprecision 1ps;

    import lws_pkg::*;

    localparam int WAYPOINT_SLOTS = 1024;
    localparam int RANDOM_ITEMS   = 280;
    localparam int CALM_TAIL      = 50;
    localparam int SETTLE_CYCLES  = 6;
    localparam int COORD_MIN      = -8388608;
    localparam int COORD_MAX      = 8388607;

    typedef enum int {
        SHAPE_WINDING,
        SHAPE_STACKED,
        SHAPE_SCATTER,
        SHAPE_HALTING,
        SHAPE_EXTREME
    } path_shape_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    lws_stream_if #(.T(req_item_t)) request_ch ();
    lws_stream_if #(.T(res_item_t)) result_ch ();

    lookahead_waypoint_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .result    (result_ch)
    );

    // own copy of the path and registers, plus the search results still due
    class waypoint_search_board;
        logic signed [COORD_W-1:0] wp_x [WAYPOINT_SLOTS];
        logic signed [COORD_W-1:0] wp_y [WAYPOINT_SLOTS];
        logic [LEN_W-1:0]          path_len;
        logic [LA_W-1:0]           reach_mm;
        res_item_t                 results_due [$];
        int                        mismatches;

        function new();
            path_len   = '0;
            reach_mm   = LOOKAHEAD_RESET;
            mismatches = 0;
            foreach (wp_x[i])
            begin
                wp_x[i] = '0;
                wp_y[i] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            if (index == CFG_PATH_LENGTH)
                path_len = value[LEN_W-1:0];
            else if (index == CFG_LOOKAHEAD)
                reach_mm = value[LA_W-1:0];
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function longint unsigned gap_sq(int k, longint px, longint py);
            longint dx;
            longint dy;
            dx = longint'(wp_x[k]) - px;
            dy = longint'(wp_y[k]) - py;
            return longint'(dx * dx + dy * dy);
        endfunction

        // direction of segment i; a zero-length segment points along +x
        function void heading(int i, output longint vx, output longint vy);
            vx = longint'(wp_x[i + 1]) - longint'(wp_x[i]);
            vy = longint'(wp_y[i + 1]) - longint'(wp_y[i]);
            if (vx == 0 && vy == 0)
                vx = 1;
        endfunction

        // line angle above ten degrees: |cross| * 2^32 > |dot| * tan10
        function bit sharp_turn(int near, int n);
            longint       ax;
            longint       ay;
            longint       bx;
            longint       by;
            longint       cr;
            longint       dt;
            logic [127:0] lhs;
            logic [127:0] rhs;
            if (near + CORNER_OFFSET + 1 >= n)
                return 1'b0;
            heading(near, ax, ay);
            heading(near + CORNER_OFFSET, bx, by);
            cr = ax * by - ay * bx;
            dt = ax * bx + ay * by;
            if (cr < 0)
                cr = -cr;
            if (dt < 0)
                dt = -dt;
            lhs = 128'(cr) << 32;
            rhs = 128'(dt) * 128'(TAN10_Q32);
            return rhs < lhs;
        endfunction

        // apply an accepted request: store a waypoint or predict a search
        function void note_request(req_item_t r);
            res_item_t         exp;
            int                n;
            int                near;
            int                target;
            longint            px;
            longint            py;
            longint unsigned   best;
            longint unsigned   d;
            longint unsigned   l2;
            if (r.func == FUNC_LOAD)
            begin
                wp_x[r.wp_index] = r.pos_x;
                wp_y[r.wp_index] = r.pos_y;
                return;
            end
            exp = '0;
            n = int'(path_len);
            if (n > WAYPOINT_SLOTS)
                n = WAYPOINT_SLOTS;
            if (n == 0)
            begin
                exp.path_empty = 1'b1;
                results_due = {results_due, exp};
                return;
            end
            px = longint'(signed'(r.pos_x));
            py = longint'(signed'(r.pos_y));
            // nearest waypoint, first index on ties
            near = 0;
            best = gap_sq(0, px, py);
            for (int i = 1; i < n; i++)
            begin
                d = gap_sq(i, px, py);
                if (d < best)
                begin
                    best = d;
                    near = i;
                end
            end
            // circular walk from nearest for the first point beyond the lookahead
            l2 = longint'(reach_mm) * longint'(reach_mm);
            target = (near + 1) % n;
            for (int i = 0; i < n; i++)
            begin
                if (gap_sq((near + i) % n, px, py) > l2)
                begin
                    target = (near + i) % n;
                    break;
                end
            end
            exp.target_index  = target[IDX_W-1:0];
            exp.nearest_index = near[IDX_W-1:0];
            exp.corner        = sharp_turn(near, n);
            results_due = {results_due, exp};
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(res_item_t got);
            res_item_t exp;
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no query pending", got));
                return;
            end
            exp = results_due.pop_front();
            if (got.target_index !== exp.target_index)
                report_mismatch($sformatf("target_index got %0d exp %0d",
                                          got.target_index, exp.target_index));
            if (got.nearest_index !== exp.nearest_index)
                report_mismatch($sformatf("nearest_index got %0d exp %0d",
                                          got.nearest_index, exp.nearest_index));
            if (got.corner !== exp.corner)
                report_mismatch($sformatf("corner got %b exp %b", got.corner, exp.corner));
            if (got.path_empty !== exp.path_empty)
                report_mismatch($sformatf("path_empty got %b exp %b",
                                          got.path_empty, exp.path_empty));
        endtask
    endclass

    waypoint_search_board board = new();

    int sent;
    int idle_pct;
    bit calm;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            board.check_result(result_ch.data);
    end

    // receiver stalls in bursts, none in the calm tail
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 7) == 0)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    end

    // hand one request over, with an optional idle burst first
    task automatic push(req_item_t r);
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.data  <= r;
        do @(posedge clk); while (request_ch.ready !== 1'b1);
        board.note_request(r);
        sent++;
        @(negedge clk);
    endtask

    // stop sending and wait for every result to come back
    task automatic settle();
        request_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] len_word, logic [CFG_W-1:0] la_word);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PATH_LENGTH;
        cfg_data  <= len_word;
        board.set_register(CFG_PATH_LENGTH, len_word);
        @(negedge clk);
        cfg_index <= CFG_LOOKAHEAD;
        cfg_data  <= la_word;
        board.set_register(CFG_LOOKAHEAD, la_word);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic ask_at(int x, int y);
        req_item_t r;
        r.func     = FUNC_QUERY;
        r.wp_index = IDX_W'($urandom_range(0, WAYPOINT_SLOTS - 1));
        r.pos_x    = x[COORD_W-1:0];
        r.pos_y    = y[COORD_W-1:0];
        push(r);
    endtask

    // query near a waypoint, exactly on one, anywhere, or at a corner of the plane
    task automatic ask(int n, int spread);
        int pick;
        int k;
        int x;
        int y;
        pick = $urandom_range(0, 9);
        if (n > 0 && pick < 7)
        begin
            k = $urandom_range(0, n - 1);
            x = board.wp_x[k];
            y = board.wp_y[k];
            if (pick >= 2)
            begin
                x += int'($urandom_range(0, 2 * spread)) - spread;
                y += int'($urandom_range(0, 2 * spread)) - spread;
            end
        end
        else if (pick < 9)
        begin
            x = $urandom;
            y = $urandom;
        end
        else
        begin
            x = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
            y = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
        end
        ask_at(x, y);
    endtask

    // stray waypoint write anywhere in the store
    task automatic scatter();
        req_item_t r;
        r.func     = FUNC_LOAD;
        r.wp_index = IDX_W'($urandom_range(0, WAYPOINT_SLOTS - 1));
        r.pos_x    = COORD_W'($urandom);
        r.pos_y    = COORD_W'($urandom);
        push(r);
    endtask

    function automatic void pick_heading(bit square, output int hx, output int hy);
        if (square)
        begin
            hx = $urandom_range(0, 1) ? 1000 : 0;
            hy = 1000 - hx;
            return;
        end
        case ($urandom_range(0, 9))
            0: begin hx = 1000;  hy = 0;    end
            1: begin hx = 1000;  hy = 170;  end
            2: begin hx = 1000;  hy = 180;  end
            3: begin hx = 0;     hy = 1000; end
            4: begin hx = -1000; hy = 0;    end
            5: begin hx = 707;   hy = 707;  end
            6: begin hx = 0;     hy = -1000; end
            7: begin hx = -1000; hy = -176; end
            8: begin hx = 1000;  hy = -200; end
            default: begin hx = 0; hy = 0; end
        endcase
    endfunction

    // load waypoints 0 .. n-1 along a path of the given shape
    task automatic lay_path(int n, path_shape_e shape, int scale);
        req_item_t r;
        int        x;
        int        y;
        int        hx;
        int        hy;
        int        run;
        x   = int'($urandom_range(0, 8000000)) - 4000000;
        y   = int'($urandom_range(0, 8000000)) - 4000000;
        run = 0;
        hx  = 0;
        hy  = 0;
        r.func = FUNC_LOAD;
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                SHAPE_SCATTER:
                begin
                    x = $urandom;
                    y = $urandom;
                end
                SHAPE_EXTREME:
                begin
                    x = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
                    y = $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
                end
                default: ;
            endcase
            r.wp_index = i[IDX_W-1:0];
            r.pos_x    = x[COORD_W-1:0];
            r.pos_y    = y[COORD_W-1:0];
            push(r);
            // advance along the current heading; halting paths repeat points
            if (shape == SHAPE_WINDING || shape == SHAPE_HALTING)
            begin
                if (run == 0)
                begin
                    pick_heading(shape == SHAPE_HALTING, hx, hy);
                    run = $urandom_range(1, 80);
                end
                if (shape == SHAPE_WINDING || $urandom_range(0, 1) == 1)
                begin
                    x += hx * scale / 1000;
                    y += hy * scale / 1000;
                end
                run--;
            end
        end
    endtask

    function automatic int pick_scale();
        case ($urandom_range(0, 4))
            0: return 1;
            1: return 7;
            2: return 300;
            3: return 1000;
            default: return 4000;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_lookahead(int scale);
        int la;
        case ($urandom_range(0, 5))
            0: la = 0;
            1: la = 65535;
            2: la = int'(LOOKAHEAD_RESET);
            3: la = $urandom_range(0, 65535);
            default: la = scale * int'($urandom_range(0, 30));
        endcase
        if (la > 65535)
            la = 65535;
        return la[CFG_W-1:0];
    endfunction

    // run limit
    initial
    begin
        #10_000_000;
        $display("tb_lookahead_waypoint_search: FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        int               base;
        int               bigs;
        int               kind;
        int               scale;
        int               eff;
        int               count;
        bit               big;
        path_shape_e      shape;
        logic [CFG_W-1:0] len_word;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        request_ch.valid = 1'b0;
        request_ch.data  = '0;
        sent             = 0;
        idle_pct         = 15;
        calm             = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty path straight out of reset
        ask_at(COORD_MIN, COORD_MAX);

        // fill the whole store so any path length reads written slots only
        lay_path(WAYPOINT_SLOTS, SHAPE_WINDING, 1000);

        // full path, ends of the path and corners of the plane
        program_regs(CFG_W'(WAYPOINT_SLOTS), LOOKAHEAD_RESET);
        ask_at(board.wp_x[0], board.wp_y[0]);
        ask_at(board.wp_x[1023], board.wp_y[1023]);
        ask_at(board.wp_x[500] + 150, board.wp_y[500] - 90);
        ask_at(COORD_MIN, COORD_MIN);
        ask_at(COORD_MAX, COORD_MAX);

        // oversized length with the longest lookahead
        program_regs(16'hFFFF, 16'hFFFF);
        ask(WAYPOINT_SLOTS, 2001);
        ask(WAYPOINT_SLOTS, 2001);

        // single waypoint, zero lookahead
        program_regs(CFG_W'(1), '0);
        ask_at(board.wp_x[0], board.wp_y[0]);
        ask_at(board.wp_x[0] + 1, board.wp_y[0]);

        // corner window just fits at nearest 0, not at nearest 1; wrap at the end
        program_regs(CFG_W'(62), CFG_W'(300));
        ask_at(board.wp_x[0], board.wp_y[0]);
        ask_at(board.wp_x[1], board.wp_y[1]);
        ask_at(board.wp_x[61], board.wp_y[61]);

        // all waypoints on one spot: ties everywhere
        lay_path(5, SHAPE_STACKED, 1);
        program_regs(CFG_W'(5), LOOKAHEAD_RESET);
        ask_at(board.wp_x[0], board.wp_y[0]);
        ask_at(board.wp_x[0] + 5000, board.wp_y[0]);

        // repeated points give zero-length segments
        lay_path(64, SHAPE_HALTING, 1000);
        program_regs(CFG_W'(64), CFG_W'(2500));
        ask_at(board.wp_x[0], board.wp_y[0]);
        ask_at(board.wp_x[2], board.wp_y[2]);
        ask_at(board.wp_x[3], board.wp_y[3]);

        // random phases: new path, new settings, a run of queries and stray loads
        base = sent;
        bigs = 0;
        while (sent - base < RANDOM_ITEMS)
        begin
            calm = (sent - base >= RANDOM_ITEMS - CALM_TAIL);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            kind  = $urandom_range(0, 9);
            scale = pick_scale();
            big   = (kind == 1 && bigs < 3);
            if (kind == 0)
                len_word = '0;
            else if (big)
            begin
                bigs++;
                case ($urandom_range(0, 2))
                    0: len_word = CFG_W'(WAYPOINT_SLOTS);
                    1: len_word = CFG_W'($urandom_range(WAYPOINT_SLOTS + 1, 2047));
                    default: len_word = 16'hF800 | CFG_W'($urandom_range(0, 2047));
                endcase
                scale = 1000;
            end
            else if (kind <= 3)
                len_word = CFG_W'($urandom_range(60, 66));
            else
                len_word = CFG_W'($urandom_range(1, 40));
            eff = int'(len_word[LEN_W-1:0]);
            if (eff > WAYPOINT_SLOTS)
                eff = WAYPOINT_SLOTS;
            if (!big && eff > 0)
            begin
                case ($urandom_range(0, 9))
                    0: shape = SHAPE_STACKED;
                    1: shape = SHAPE_SCATTER;
                    2: shape = SHAPE_EXTREME;
                    3, 4: shape = SHAPE_HALTING;
                    default: shape = SHAPE_WINDING;
                endcase
                lay_path(eff, shape, scale);
            end
            program_regs(len_word, pick_lookahead(scale));
            count = big ? $urandom_range(3, 5) : $urandom_range(8, 20);
            repeat (count)
            begin
                // now and then hold off until the block has drained
                if ($urandom_range(0, 19) == 0)
                    settle();
                if ($urandom_range(0, 99) < 15)
                    scatter();
                else
                    ask(eff, 2 * scale + 1);
            end
        end

        // drain and decide
        settle();
        repeat (20) @(negedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_lookahead_waypoint_search: PASS");
        else
            $display("tb_lookahead_waypoint_search: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/lws_pkg.sv
design/lws_stream_if.sv
design/lws_datapath.sv
design/lws_ctrl.sv
design/lookahead_waypoint_search.sv
verif/tb_lookahead_waypoint_search.sv
